// ----- hw/rtl/bhtq_pkg.sv -----
// ----------------------------------------------------------------------------
// bhtq_pkg
// Shared types and constants of the button hold / tap qualifier.
// ----------------------------------------------------------------------------
`default_nettype none

package bhtq_pkg;

  localparam int NUM_PADS_DEF  = 4;
  localparam int NUM_SLOTS_DEF = 4;

  localparam int FUNC_W     = 2;
  localparam int ACT_W      = 6;
  localparam int BTN_W      = 5;
  localparam int PAD_W      = 2;
  localparam int NOW_W      = 32;
  localparam int CONN_W     = 4;
  localparam int MASK_W     = 32;
  localparam int KIND_W     = 2;
  localparam int HOLD_W     = 24;
  localparam int CODE_W     = 6;
  localparam int PADS_IN    = 4;
  localparam int REG_SLOTS  = 4;
  localparam int REG_IDX_W  = 2;
  localparam int SLOT_EXT_W = 3;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 24;
  localparam int REC_W      = NOW_W + BTN_W + ACT_W;

  localparam logic [CFG_IDX_W-1:0] REG_HOLD_BASE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_BASE = 4'd4;

  typedef logic [HOLD_W-1:0] hold_t;
  typedef logic [CODE_W-1:0] code_t;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PRESS = 2'd0,
    FUNC_POLL  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_HANDLED   = 2'd0,
    KIND_UNHANDLED = 2'd1,
    KIND_HOLD      = 2'd2,
    KIND_TAP       = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_PRESSED = 2'd1,
    PH_FIRED   = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRESS,
    ST_POLL,
    ST_EVAL,
    ST_EMIT,
    ST_MISC
  } seq_state_t;

  typedef struct packed {
    logic                 clr;
    logic [REG_IDX_W-1:0] slot;
  } slot_clr_t;

  typedef struct packed {
    kind_t            kind;
    logic [PAD_W-1:0] pad;
    logic [BTN_W-1:0] button;
    logic [ACT_W-1:0] action;
  } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bhtq_ram.sv -----
// ----------------------------------------------------------------------------
// bhtq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bhtq_ram #(
  parameter int WIDTH = bhtq_pkg::REC_W,
  parameter int DEPTH = bhtq_pkg::NUM_PADS_DEF * bhtq_pkg::NUM_SLOTS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH)-1:0]         waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic                             re,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr,
  output logic      [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/bhtq_cfg.sv -----
// ----------------------------------------------------------------------------
// bhtq_cfg
// Slot configuration registers: hold thresholds and action codes.
// ----------------------------------------------------------------------------
`default_nettype none

module bhtq_cfg (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_we,
  input  wire logic [bhtq_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  wire logic [bhtq_pkg::CFG_DATA_W-1:0]      cfg_data,
  output bhtq_pkg::hold_t                           hold [bhtq_pkg::REG_SLOTS],
  output bhtq_pkg::code_t                           code [bhtq_pkg::REG_SLOTS],
  output bhtq_pkg::slot_clr_t                       slot_clr
);

  bhtq_pkg::hold_t hold_r [bhtq_pkg::REG_SLOTS];
  bhtq_pkg::code_t code_r [bhtq_pkg::REG_SLOTS];
  logic            hit_hold;
  logic            hit_code;
  logic [bhtq_pkg::REG_IDX_W-1:0] slot;

  always_comb begin
    hit_hold = cfg_we && (cfg_idx < bhtq_pkg::REG_CODE_BASE);
    hit_code = cfg_we && (cfg_idx >= bhtq_pkg::REG_CODE_BASE) &&
               (cfg_idx < bhtq_pkg::REG_CODE_BASE +
                          bhtq_pkg::CFG_IDX_W'(bhtq_pkg::REG_SLOTS));
    slot     = cfg_idx[bhtq_pkg::REG_IDX_W-1:0];
    slot_clr.clr  = hit_hold || hit_code;
    slot_clr.slot = slot;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < bhtq_pkg::REG_SLOTS; k++) begin
        hold_r[k] <= '0;
        code_r[k] <= '0;
      end
    end else begin
      if (hit_hold) begin
        hold_r[slot] <= cfg_data;
      end
      if (hit_code) begin
        code_r[slot] <= cfg_data[bhtq_pkg::CODE_W-1:0];
      end
    end
  end

  assign hold = hold_r;
  assign code = code_r;

endmodule

`default_nettype wire

// ----- hw/rtl/bhtq_seq.sv -----
// ----------------------------------------------------------------------------
// bhtq_seq
// Record sequencer: walks slot/pad records one per step through a single
// compare/subtract unit; phases in flops, record data in RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module bhtq_seq #(
  parameter int NUM_PADS  = bhtq_pkg::NUM_PADS_DEF,
  parameter int NUM_SLOTS = bhtq_pkg::NUM_SLOTS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [bhtq_pkg::FUNC_W-1:0]      in_func,
  input  wire logic [bhtq_pkg::ACT_W-1:0]       in_action,
  input  wire logic [bhtq_pkg::BTN_W-1:0]       in_button,
  input  wire logic [bhtq_pkg::PAD_W-1:0]       in_pad,
  input  wire logic [bhtq_pkg::NOW_W-1:0]       in_now,
  input  wire logic [bhtq_pkg::CONN_W-1:0]      in_connected,
  input  wire logic [bhtq_pkg::MASK_W-1:0]      in_masks [bhtq_pkg::PADS_IN],
  input  wire bhtq_pkg::hold_t                  hold [bhtq_pkg::REG_SLOTS],
  input  wire bhtq_pkg::code_t                  code [bhtq_pkg::REG_SLOTS],
  input  wire bhtq_pkg::slot_clr_t              slot_clr,
  output logic                                  res_valid,
  input  wire logic                             res_ready,
  output bhtq_pkg::result_t                     res
);

  localparam int SW    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int PW    = (NUM_PADS > 1) ? $clog2(NUM_PADS) : 1;
  localparam int AW    = SW + PW;
  localparam int DEPTH = 1 << AW;
  localparam logic [SW-1:0] S_LAST = SW'(NUM_SLOTS - 1);
  localparam logic [PW-1:0] P_LAST = PW'(NUM_PADS - 1);

  bhtq_pkg::seq_state_t state_r, state_nxt;
  logic [SW-1:0]        s_r, s_nxt;
  logic [PW-1:0]        p_r, p_nxt;
  bhtq_pkg::result_t    res_r, res_nxt;

  bhtq_pkg::func_t                   func_r;
  logic [bhtq_pkg::ACT_W-1:0]        action_r;
  logic [bhtq_pkg::BTN_W-1:0]        button_r;
  logic [bhtq_pkg::PAD_W-1:0]        pad_r;
  logic [bhtq_pkg::NOW_W-1:0]        now_r;
  logic [bhtq_pkg::CONN_W-1:0]       conn_r;
  logic [bhtq_pkg::MASK_W-1:0]       mask_r [bhtq_pkg::PADS_IN];
  bhtq_pkg::phase_t                  phase_r [NUM_SLOTS][NUM_PADS];

  logic                              load;
  logic                              clr_all;
  logic                              ph_we;
  logic [PW-1:0]                     ph_p;
  bhtq_pkg::phase_t                  ph_val;
  logic                              ram_we;
  logic                              ram_re;
  logic [bhtq_pkg::REC_W-1:0]        rdata;

  logic [bhtq_pkg::SLOT_EXT_W-1:0]   s_ext;
  logic [bhtq_pkg::SLOT_EXT_W-1:0]   p_ext;
  logic                              slot_en;
  logic                              pad_live;
  logic                              press_pad_ok;
  logic                              last_rec;
  logic [SW-1:0]                     adv_s;
  logic [PW-1:0]                     adv_p;
  logic [bhtq_pkg::NOW_W-1:0]        rd_time;
  logic [bhtq_pkg::BTN_W-1:0]        rd_btn;
  logic [bhtq_pkg::ACT_W-1:0]        rd_act;
  logic [bhtq_pkg::NOW_W-1:0]        elapsed;
  logic                              held;
  logic                              fire;
  bhtq_pkg::hold_t                   cur_hold;

  bhtq_ram #(
    .WIDTH (bhtq_pkg::REC_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr ({s_r, PW'(pad_r)}),
    .wdata ({now_r, button_r, action_r}),
    .re    (ram_re),
    .raddr ({s_r, p_r}),
    .rdata (rdata)
  );

  // shared unit: slot enable, pad liveness, elapsed-time subtract and compare
  always_comb begin
    s_ext        = bhtq_pkg::SLOT_EXT_W'(s_r);
    p_ext        = bhtq_pkg::SLOT_EXT_W'(p_r);
    cur_hold     = hold[s_ext[bhtq_pkg::REG_IDX_W-1:0]];
    slot_en      = (s_ext < bhtq_pkg::SLOT_EXT_W'(bhtq_pkg::REG_SLOTS)) && (cur_hold != '0);
    pad_live     = (p_ext < bhtq_pkg::SLOT_EXT_W'(bhtq_pkg::PADS_IN)) &&
                   conn_r[p_ext[bhtq_pkg::PAD_W-1:0]];
    press_pad_ok = (4'(pad_r) < 4'(NUM_PADS));
    last_rec     = (s_r == S_LAST) && (p_r == P_LAST);
    adv_s        = (s_r == S_LAST) ? '0 : s_r + SW'(1);
    adv_p        = (s_r == S_LAST) ? p_r + PW'(1) : p_r;
    {rd_time, rd_btn, rd_act} = rdata;
    elapsed      = now_r - rd_time;
    fire         = elapsed >= bhtq_pkg::NOW_W'(cur_hold);
    held         = mask_r[p_ext[bhtq_pkg::PAD_W-1:0]][rd_btn];
  end

  always_comb begin
    state_nxt = state_r;
    s_nxt     = s_r;
    p_nxt     = p_r;
    res_nxt   = res_r;
    in_ready  = 1'b0;
    res_valid = 1'b0;
    load      = 1'b0;
    clr_all   = 1'b0;
    ph_we     = 1'b0;
    ph_p      = p_r;
    ph_val    = bhtq_pkg::PH_IDLE;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    unique case (state_r)
      bhtq_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          load  = 1'b1;
          s_nxt = '0;
          p_nxt = '0;
          unique case (bhtq_pkg::func_t'(in_func))
            bhtq_pkg::FUNC_PRESS: state_nxt = bhtq_pkg::ST_PRESS;
            bhtq_pkg::FUNC_POLL:  state_nxt = bhtq_pkg::ST_POLL;
            default:              state_nxt = bhtq_pkg::ST_MISC;
          endcase
        end
      end
      bhtq_pkg::ST_PRESS: begin
        res_nxt.pad    = pad_r;
        res_nxt.button = button_r;
        res_nxt.action = action_r;
        res_nxt.kind   = bhtq_pkg::KIND_UNHANDLED;
        if (!press_pad_ok) begin
          state_nxt = bhtq_pkg::ST_EMIT;
        end else if (slot_en && (code[s_ext[bhtq_pkg::REG_IDX_W-1:0]] == action_r)) begin
          ram_we       = 1'b1;
          ph_we        = 1'b1;
          ph_p         = PW'(pad_r);
          ph_val       = bhtq_pkg::PH_PRESSED;
          res_nxt.kind = bhtq_pkg::KIND_HANDLED;
          state_nxt    = bhtq_pkg::ST_EMIT;
        end else if (s_r == S_LAST) begin
          state_nxt = bhtq_pkg::ST_EMIT;
        end else begin
          s_nxt = adv_s;
        end
      end
      bhtq_pkg::ST_POLL: begin
        if (pad_live && slot_en && (phase_r[s_r][p_r] != bhtq_pkg::PH_IDLE)) begin
          ram_re    = 1'b1;
          state_nxt = bhtq_pkg::ST_EVAL;
        end else if (last_rec) begin
          state_nxt = bhtq_pkg::ST_IDLE;
        end else begin
          s_nxt = adv_s;
          p_nxt = adv_p;
        end
      end
      bhtq_pkg::ST_EVAL: begin
        res_nxt.pad    = bhtq_pkg::PAD_W'(p_r);
        res_nxt.button = rd_btn;
        res_nxt.action = rd_act;
        res_nxt.kind   = bhtq_pkg::KIND_HOLD;
        if (held && (phase_r[s_r][p_r] == bhtq_pkg::PH_PRESSED) && fire) begin
          ph_we     = 1'b1;
          ph_val    = bhtq_pkg::PH_FIRED;
          state_nxt = bhtq_pkg::ST_EMIT;
        end else if (!held && (phase_r[s_r][p_r] == bhtq_pkg::PH_PRESSED)) begin
          ph_we        = 1'b1;
          res_nxt.kind = bhtq_pkg::KIND_TAP;
          state_nxt    = bhtq_pkg::ST_EMIT;
        end else begin
          ph_we = !held;
          if (last_rec) begin
            state_nxt = bhtq_pkg::ST_IDLE;
          end else begin
            s_nxt     = adv_s;
            p_nxt     = adv_p;
            state_nxt = bhtq_pkg::ST_POLL;
          end
        end
      end
      bhtq_pkg::ST_EMIT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = bhtq_pkg::ST_IDLE;
        end
      end
      bhtq_pkg::ST_MISC: begin
        clr_all   = (func_r == bhtq_pkg::FUNC_CLEAR);
        state_nxt = bhtq_pkg::ST_IDLE;
      end
      default: state_nxt = bhtq_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bhtq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r   <= s_nxt;
    p_r   <= p_nxt;
    res_r <= res_nxt;
    if (load) begin
      func_r   <= bhtq_pkg::func_t'(in_func);
      action_r <= in_action;
      button_r <= in_button;
      pad_r    <= in_pad;
      now_r    <= in_now;
      conn_r   <= in_connected;
      mask_r   <= in_masks;
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < NUM_SLOTS; s++) begin
      for (int p = 0; p < NUM_PADS; p++) begin
        if (!rst_n || clr_all ||
            (slot_clr.clr && (4'(slot_clr.slot) == 4'(s)))) begin
          phase_r[s][p] <= bhtq_pkg::PH_IDLE;
        end else if (ph_we && (s_r == SW'(s)) && (ph_p == PW'(p))) begin
          phase_r[s][p] <= ph_val;
        end
      end
    end
  end

  assign res = res_r;

endmodule

`default_nettype wire

// ----- hw/rtl/button_hold_tap_qualifier_top.sv -----
// ----------------------------------------------------------------------------
// button_hold_tap_qualifier_top
// Long-press qualifier: arms per-slot, per-pad records on press events and
// reports hold or tap on polls.
// ----------------------------------------------------------------------------
// One word is handled at a time; in_ready is low until it is done. A press
// compares one slot per cycle and stops at the first matching slot or the
// last slot, then hands off its result. A poll visits the NUM_SLOTS x NUM_PADS
// records in pad order, skipping idle, disabled or unconnected records without
// a RAM read; an armed one takes a record RAM read, then the elapsed-time
// compare. The poll stops at the first hold or tap and hands off a result
// when one is found. Clear and the unused code pass through the misc state
// back to idle. All records share the single compare and subtract unit and
// the one RAM read port. A finished result sits in the output register while
// the next word is taken.
`default_nettype none

module button_hold_tap_qualifier_top #(
  parameter int NUM_PADS  = bhtq_pkg::NUM_PADS_DEF,
  parameter int NUM_SLOTS = bhtq_pkg::NUM_SLOTS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [bhtq_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [bhtq_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [bhtq_pkg::FUNC_W-1:0]      in_func,
  input  wire logic [bhtq_pkg::ACT_W-1:0]       in_action,
  input  wire logic [bhtq_pkg::BTN_W-1:0]       in_button,
  input  wire logic [bhtq_pkg::PAD_W-1:0]       in_pad,
  input  wire logic [bhtq_pkg::NOW_W-1:0]       in_now,
  input  wire logic [bhtq_pkg::CONN_W-1:0]      in_connected,
  input  wire logic [bhtq_pkg::MASK_W-1:0]      in_pad0_buttons,
  input  wire logic [bhtq_pkg::MASK_W-1:0]      in_pad1_buttons,
  input  wire logic [bhtq_pkg::MASK_W-1:0]      in_pad2_buttons,
  input  wire logic [bhtq_pkg::MASK_W-1:0]      in_pad3_buttons,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [bhtq_pkg::KIND_W-1:0]           out_kind,
  output logic [bhtq_pkg::PAD_W-1:0]            out_pad,
  output logic [bhtq_pkg::BTN_W-1:0]            out_button,
  output logic [bhtq_pkg::ACT_W-1:0]            out_action
);

  bhtq_pkg::hold_t      hold [bhtq_pkg::REG_SLOTS];
  bhtq_pkg::code_t      code [bhtq_pkg::REG_SLOTS];
  bhtq_pkg::slot_clr_t  slot_clr;
  logic [bhtq_pkg::MASK_W-1:0] masks [bhtq_pkg::PADS_IN];
  logic                 res_valid;
  logic                 res_ready;
  bhtq_pkg::result_t    res;
  logic                 out_valid_r;
  bhtq_pkg::result_t    out_res_r;

  assign masks[0] = in_pad0_buttons;
  assign masks[1] = in_pad1_buttons;
  assign masks[2] = in_pad2_buttons;
  assign masks[3] = in_pad3_buttons;

  bhtq_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .hold     (hold),
    .code     (code),
    .slot_clr (slot_clr)
  );

  bhtq_seq #(
    .NUM_PADS  (NUM_PADS),
    .NUM_SLOTS (NUM_SLOTS)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_func      (in_func),
    .in_action    (in_action),
    .in_button    (in_button),
    .in_pad       (in_pad),
    .in_now       (in_now),
    .in_connected (in_connected),
    .in_masks     (masks),
    .hold         (hold),
    .code         (code),
    .slot_clr     (slot_clr),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res)
  );

  // output word register
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_kind   = out_res_r.kind;
  assign out_pad    = out_res_r.pad;
  assign out_button = out_res_r.button;
  assign out_action = out_res_r.action;

endmodule

`default_nettype wire

// ----- hw/rtl/bhtq_checker.sv -----
// ----------------------------------------------------------------------------
// bhtq_checker
// Port-level checks of the hold / tap qualifier, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bhtq_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_valid,
  input wire logic                             in_ready,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire logic [bhtq_pkg::KIND_W-1:0]      out_kind,
  input wire logic [bhtq_pkg::PAD_W-1:0]       out_pad,
  input wire logic [bhtq_pkg::BTN_W-1:0]       out_button,
  input wire logic [bhtq_pkg::ACT_W-1:0]       out_action
);

  // one word at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready high right after an accepted word");

  // reset leaves the block ready and empty
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("block not idle after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_pad) &&
                               $stable(out_button) && $stable(out_action))
    else $error("stalled result word changed");

endmodule

bind button_hold_tap_qualifier_top bhtq_checker u_bhtq_checker (.*);

`default_nettype wire
